// ===== design/decimal_to_seven_segment_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal to seven-segment unit
// Shared concurrent-check shorthands, all synchronous to one clock with a
// reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH
`define DECIMAL_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Widths, the digit-to-segment table and the divide-by-ten constants shared
// by the decimal to seven-segment unit.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Payload widths
  localparam int VALUE_W = 27;
  localparam int SEG_W   = 8;
  localparam int NPOS    = 8;
  localparam int DIGIT_W = 4;

  // Divide by ten: q = (x * RECIP) >> RECIP_SHIFT, exact for any 32-bit x
  localparam int                 RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 PROD_W      = VALUE_W + RECIP_W;
  localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

  // Segment bits, bit0 = a .. bit6 = g, dot off
  localparam logic [SEG_W-1:0] SEG_A = 8'h01;
  localparam logic [SEG_W-1:0] SEG_B = 8'h02;
  localparam logic [SEG_W-1:0] SEG_C = 8'h04;
  localparam logic [SEG_W-1:0] SEG_D = 8'h08;
  localparam logic [SEG_W-1:0] SEG_E = 8'h10;
  localparam logic [SEG_W-1:0] SEG_F = 8'h20;
  localparam logic [SEG_W-1:0] SEG_G = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // Word moved from one cell to the next
  typedef struct packed {
    logic [VALUE_W-1:0]          rest;
    logic [NPOS-1:0][SEG_W-1:0]  seg;
  } dss_word_t;

  // Digit to segment pattern
  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    s = SEG_BLANK;
    unique case (d)
      4'd0:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    s = SEG_B | SEG_C;
      4'd2:    s = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    s = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5:    s = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      4'd6:    s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    s = SEG_A | SEG_B | SEG_C;
      4'd8:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== design/dss_in_if.sv =====
// ----------------------------------------------------------------------------
// dss_in_if
// Value channel: valid/ready handshake carrying one unsigned value per word.
// ----------------------------------------------------------------------------
interface dss_in_if;
  logic                        valid;
  logic                        ready;
  logic [dss_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/dss_out_if.sv =====
// ----------------------------------------------------------------------------
// dss_out_if
// Display channel: valid/ready handshake carrying eight segment bytes per word.
// ----------------------------------------------------------------------------
interface dss_out_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::SEG_W-1:0] seg_pos0;
  logic [dss_pkg::SEG_W-1:0] seg_pos1;
  logic [dss_pkg::SEG_W-1:0] seg_pos2;
  logic [dss_pkg::SEG_W-1:0] seg_pos3;
  logic [dss_pkg::SEG_W-1:0] seg_pos4;
  logic [dss_pkg::SEG_W-1:0] seg_pos5;
  logic [dss_pkg::SEG_W-1:0] seg_pos6;
  logic [dss_pkg::SEG_W-1:0] seg_pos7;

  modport source (output valid, input ready, output seg_pos0, output seg_pos1,
                  output seg_pos2, output seg_pos3, output seg_pos4,
                  output seg_pos5, output seg_pos6, output seg_pos7);
  modport sink   (input valid, output ready, input seg_pos0, input seg_pos1,
                  input seg_pos2, input seg_pos3, input seg_pos4,
                  input seg_pos5, input seg_pos6, input seg_pos7);
endinterface

// ===== design/dss_cell.sv =====
// ----------------------------------------------------------------------------
// dss_cell
// One digit cell: divides the remaining quotient by ten, turns the remainder
// into its segment byte and registers the word for the next cell.
// ----------------------------------------------------------------------------
`include "decimal_to_seven_segment_unit_macros.svh"

module dss_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  input  dss_pkg::dss_word_t up_word,
  output logic               up_ready,
  output logic               valid,
  output dss_pkg::dss_word_t word,
  input  logic               down_ready
);

  // Display slot fed by this cell; cells past the display only pass along
  localparam bool_shown = (IDX < dss_pkg::NPOS);
  localparam int  SLOT  = bool_shown ? (dss_pkg::NPOS - 1 - IDX) : 0;

  logic [dss_pkg::PROD_W-1:0]  prod;
  logic [dss_pkg::QUOT_W-1:0]  quot;
  logic [dss_pkg::VALUE_W-1:0] quot10;
  logic [dss_pkg::DIGIT_W-1:0] rem;
  logic [dss_pkg::SEG_W-1:0]   code;
  dss_pkg::dss_word_t          word_next;

  // Divide by ten via reciprocal multiply, remainder by shift-add
  always_comb begin
    prod   = dss_pkg::PROD_W'(up_word.rest) * dss_pkg::PROD_W'(dss_pkg::RECIP);
    quot   = prod[dss_pkg::PROD_W-1:dss_pkg::RECIP_SHIFT];
    quot10 = dss_pkg::VALUE_W'({quot, 3'b000}) + dss_pkg::VALUE_W'({quot, 1'b0});
    rem    = dss_pkg::DIGIT_W'(up_word.rest - quot10);
  end

  // Units cell always draws its digit; higher cells blank once rest is zero
  always_comb begin
    if (IDX == 0 || up_word.rest != '0) begin
      code = dss_pkg::seg_of_digit(rem);
    end else begin
      code = dss_pkg::SEG_BLANK;
    end
    word_next      = up_word;
    word_next.rest = dss_pkg::VALUE_W'(quot);
    if (bool_shown) begin
      word_next.seg[SLOT] = code;
    end
  end

  // Stage moves when empty or when the next cell takes its word
  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word <= word_next;
    end
  end

  // Checks
  `DSS_ASSERT_NEXT(a_stall_hold, clk, rst, valid && !down_ready, valid && $stable(word), "dss_cell: stalled word changed")
  `DSS_ASSERT_NEXT(a_load, clk, rst, up_valid && up_ready, valid, "dss_cell: accepted word lost")
  `DSS_ASSERT_NOW(a_units_lit, clk, rst, valid && IDX == 0, word.seg[SLOT] != dss_pkg::SEG_BLANK, "dss_cell: units digit blank")
  `DSS_ASSERT_NOW(a_blank_done, clk, rst, valid && bool_shown && word.seg[SLOT] == dss_pkg::SEG_BLANK, word.rest == '0, "dss_cell: blank digit with rest left")

endmodule

// ===== design/decimal_to_seven_segment_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_to_seven_segment_unit
// Turns an unsigned value into eight seven-segment bytes, units digit at
// position 7, leading positions blank.
// ----------------------------------------------------------------------------
// Usage:
//   num  : value words in, valid/ready handshake, taken when both are high.
//   disp : one word of eight segment bytes out per value, same order.
//   The block is a row of DIGITS digit cells. Each cell strips one decimal
//   digit with a reciprocal multiply and registers the word for the next.
//   Each cell registers the word, so a value passes every cell in turn before disp.valid.
//   Throughput is one value per cycle while disp.ready is high; each cell's single multiplier is the
//   one unit on the path, and every cell holds its own word.
//   When disp.ready is low, the last cell holds its word and the stall
//   backs up cell by cell; num.ready stays high while any cell is empty,
//   so bubbles are squeezed out before the input stops.
//   Reset (rst, synchronous) clears all cell valid flags; no word is lost
//   or shown from before reset. No setup or clearing pass is needed.
// ----------------------------------------------------------------------------
module decimal_to_seven_segment_unit #(
  parameter int DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  dss_in_if.sink     num,
  dss_out_if.source  disp
);

  logic               valid_c [DIGITS+1];
  logic               ready_c [DIGITS+1];
  dss_pkg::dss_word_t word_c  [DIGITS+1];

  // Chain head: input word with all positions blank
  assign valid_c[0]            = num.valid;
  assign word_c[0].rest        = num.value;
  assign word_c[0].seg         = '0;
  assign num.ready             = ready_c[0];
  assign ready_c[DIGITS]       = disp.ready;

  // Row of digit cells
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    dss_cell #(
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (valid_c[k]),
      .up_word    (word_c[k]),
      .up_ready   (ready_c[k]),
      .valid      (valid_c[k+1]),
      .word       (word_c[k+1]),
      .down_ready (ready_c[k+1])
    );
  end

  // Output word from the last cell
  assign disp.valid    = valid_c[DIGITS];
  assign disp.seg_pos0 = word_c[DIGITS].seg[0];
  assign disp.seg_pos1 = word_c[DIGITS].seg[1];
  assign disp.seg_pos2 = word_c[DIGITS].seg[2];
  assign disp.seg_pos3 = word_c[DIGITS].seg[3];
  assign disp.seg_pos4 = word_c[DIGITS].seg[4];
  assign disp.seg_pos5 = word_c[DIGITS].seg[5];
  assign disp.seg_pos6 = word_c[DIGITS].seg[6];
  assign disp.seg_pos7 = word_c[DIGITS].seg[7];

endmodule

// ===== dv/tb_decimal_to_seven_segment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_to_seven_segment_unit
// Drives values into the decimal to seven-segment unit through its handshake
// channels and checks every display word against an independent
// digit-by-digit decode. Both sides idle in random bursts. One long output
// hold backs the pipeline up until the input stalls.
// ----------------------------------------------------------------------------
module tb_decimal_to_seven_segment_unit;

  typedef logic [dss_pkg::NPOS-1:0][dss_pkg::SEG_W-1:0] display_t;

  // Glyphs indexed by decimal digit, digit 9 at the top
  localparam logic [9:0][dss_pkg::SEG_W-1:0] GLYPHS = {
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_C | dss_pkg::SEG_D |
      dss_pkg::SEG_F | dss_pkg::SEG_G,
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_C | dss_pkg::SEG_D |
      dss_pkg::SEG_E | dss_pkg::SEG_F | dss_pkg::SEG_G,
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_C,
    dss_pkg::SEG_A | dss_pkg::SEG_C | dss_pkg::SEG_D | dss_pkg::SEG_E |
      dss_pkg::SEG_F | dss_pkg::SEG_G,
    dss_pkg::SEG_A | dss_pkg::SEG_C | dss_pkg::SEG_D | dss_pkg::SEG_F |
      dss_pkg::SEG_G,
    dss_pkg::SEG_B | dss_pkg::SEG_C | dss_pkg::SEG_F | dss_pkg::SEG_G,
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_C | dss_pkg::SEG_D |
      dss_pkg::SEG_G,
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_D | dss_pkg::SEG_E |
      dss_pkg::SEG_G,
    dss_pkg::SEG_B | dss_pkg::SEG_C,
    dss_pkg::SEG_A | dss_pkg::SEG_B | dss_pkg::SEG_C | dss_pkg::SEG_D |
      dss_pkg::SEG_E | dss_pkg::SEG_F
  };

  localparam int LATENCY      = 8;
  localparam int N_DIRECTED   = 22;
  localparam int N_RANDOM     = 668;
  localparam int N_QUIET      = 100;
  localparam int N_BURST      = 60;
  localparam int HOLD_CYCLES  = 90;

  // Expected display words in acceptance order
  class display_tracker;
    typedef struct {
      logic [dss_pkg::VALUE_W-1:0] value;
      display_t                    segs;
    } pending_t;

    pending_t pending_displays[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Decimal digits from the low end, units at the last position
    function display_t digits_to_segments(input logic [dss_pkg::VALUE_W-1:0] v);
      display_t    d;
      int unsigned rest;
      int          k;
      d    = '0;
      rest = 32'(v);
      if (rest == 0) begin
        d[dss_pkg::NPOS-1] = GLYPHS[0];
      end else begin
        for (k = 0; k < dss_pkg::NPOS; k++) begin
          if (rest != 0) begin
            d[dss_pkg::NPOS-1-k] = GLYPHS[rest % 10];
            rest                 = rest / 10;
          end
        end
      end
      return d;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    function void note_value(input logic [dss_pkg::VALUE_W-1:0] v);
      pending_t e;
      e.value = v;
      e.segs  = digits_to_segments(v);
      pending_displays.push_back(e);
    endfunction

    task check_display(input display_t got);
      pending_t e;
      int       p;
      if (pending_displays.size() == 0) begin
        report($sformatf("display word %h with no value outstanding", got));
        return;
      end
      e = pending_displays.pop_front();
      for (p = 0; p < dss_pkg::NPOS; p++) begin
        if (got[p] !== e.segs[p])
          report($sformatf("value %0d seg_pos%0d got %h want %h",
                           e.value, p, got[p], e.segs[p]));
      end
    endtask

    function int outstanding();
      return pending_displays.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  dss_in_if  num_if ();
  dss_out_if disp_if ();

  decimal_to_seven_segment_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .num  (num_if),
    .disp (disp_if)
  );

  display_tracker tracker = new();

  bit idle_on  = 1'b1;
  bit hold_now = 1'b0;

  int unsigned directed_values [N_DIRECTED] = '{
    0, 1, 9, 10, 100, 101, 7,
    1000000, 10000000, 12345678, 87654321, 90909090, 11111111,
    89012345, 1234567, 99999990, 99999999,
    100000000, 100000001, 67108864, 32'h5555555, 32'h7FFFFFF
  };

  always #6 clk = ~clk;

  // Watch both channels; handshakes read as they stood before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (disp_if.valid && disp_if.ready)
        tracker.check_display({disp_if.seg_pos7, disp_if.seg_pos6,
                               disp_if.seg_pos5, disp_if.seg_pos4,
                               disp_if.seg_pos3, disp_if.seg_pos2,
                               disp_if.seg_pos1, disp_if.seg_pos0});
      if (num_if.valid && num_if.ready)
        tracker.note_value(num_if.value);
    end
  end

  // Display side: random ready bursts, one long hold on request
  initial begin
    disp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_now) begin
        disp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        disp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        disp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one word and wait until it is taken
  task automatic send_value(input logic [dss_pkg::VALUE_W-1:0] v);
    num_if.valid <= 1'b1;
    num_if.value <= v;
    do @(posedge clk); while (!num_if.ready);
  endtask

  // Random gap on the value side, junk on the bus while idle
  task automatic value_gap();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      num_if.valid <= 1'b0;
      num_if.value <= dss_pkg::VALUE_W'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Mostly values of a random digit count, some zero-heavy, some past eight digits
  function automatic logic [dss_pkg::VALUE_W-1:0] next_test_value();
    int unsigned pow10 [9] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                               10000000, 100000000};
    int unsigned v;
    int          n;
    int          k;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      v = $urandom;
    end else if (sel == 1) begin
      v = $urandom_range(134217727, 100000000);
    end else if (sel <= 3) begin
      v = 0;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        v = v * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 9));
    end else begin
      n = $urandom_range(1, 8);
      v = $urandom_range(pow10[n] - 1, (n == 1) ? 0 : pow10[n-1]);
    end
    return v[dss_pkg::VALUE_W-1:0];
  endfunction

  // Main sequence
  initial begin
    int i;
    num_if.valid <= 1'b0;
    num_if.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corner values
    for (i = 0; i < N_DIRECTED; i++) begin
      send_value(directed_values[i][dss_pkg::VALUE_W-1:0]);
      value_gap();
    end

    // back-to-back values against a long output hold
    hold_now = 1'b1;
    for (i = 0; i < N_BURST; i++)
      send_value(next_test_value());

    // random values, last stretch with no idling
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_QUIET) idle_on = 1'b0;
      send_value(next_test_value());
      value_gap();
    end
    num_if.valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2 * LATENCY + 4) @(posedge clk);

    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
